// ----- hdl/pfsb_pkg.sv -----
// Package for the prefetch FIFO with skid buffer.
// Sizes, beat layouts and the controller/datapath command and status types.
// No dependencies.
package pfsb_pkg;

  localparam int unsigned ADDR_BITS  = 10;
  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned DEPTH      = 1 << ADDR_BITS;
  localparam int unsigned CNT_W      = ADDR_BITS + 1;

  // input beat: write_request, write_word, consumer_ready, flush
  localparam int unsigned IN_BITS  = 1 + DATA_WIDTH + 1 + 1;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  // result beat: head_word, head_valid, is_full, is_empty, occupancy, write_accepted
  localparam int unsigned OUT_BITS = DATA_WIDTH + 1 + 1 + 1 + CNT_W + 1;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic step;   // beat accepted: evaluate one tick
    logic push;   // store write word
    logic rd;     // read ahead at read position
    logic flush;  // empty FIFO and output path
    logic ready;  // consumer takes head word
  } pfsb_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic skid_held;
    logic pending;
  } pfsb_status_t;

endpackage

// ----- hdl/pfsb_ctrl.sv -----
// Controller of the prefetch FIFO: beat handshake state machine and tick decisions.
// Depends on pfsb_pkg.
module pfsb_ctrl import pfsb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         wreq_i,
  input  logic         consumer_ready_i,
  input  logic         flush_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  pfsb_status_t status_i,
  output pfsb_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign in_ready_o  = (state_q == ST_IDLE) || out_ready_i;
  assign out_valid_o = (state_q == ST_HOLD);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (accept)           state_d = ST_HOLD;
        else if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    cmd_o.step  = accept;
    cmd_o.flush = flush_i;
    cmd_o.ready = consumer_ready_i;
    cmd_o.push  = wreq_i && !status_i.full && !flush_i;
    // read ahead while output path has room
    if (status_i.empty || flush_i) cmd_o.rd = 1'b0;
    else if (consumer_ready_i)     cmd_o.rd = !(status_i.skid_held && status_i.pending);
    else                           cmd_o.rd = !status_i.skid_held && !status_i.pending;
  end

endmodule

// ----- hdl/pfsb_datapath.sv -----
// Datapath of the prefetch FIFO: pointers, count, storage memory, skid and result register.
// Depends on pfsb_pkg.
module pfsb_datapath import pfsb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pfsb_cmd_t        cmd_i,
  input  data_t            wdata_i,
  output pfsb_status_t     status_o,
  output logic [OUT_W-1:0] result_o
);

  data_t mem [DEPTH];

  addr_t wr_ptr_q, rd_ptr_q;
  cnt_t  cnt_q;
  data_t mem_ret_q;
  logic  pending_q;
  data_t skid_word_q;
  logic  skid_held_q;
  logic [OUT_W-1:0] result_q;

  logic  full, empty, head_valid, taken;
  data_t head_word;
  logic [OUT_W-1:0] result_d;

  assign empty      = (wr_ptr_q == rd_ptr_q);
  assign full       = (addr_t'(wr_ptr_q + addr_t'(1)) == rd_ptr_q);
  assign head_valid = skid_held_q || pending_q;
  assign head_word  = !head_valid ? '0 : (skid_held_q ? skid_word_q : mem_ret_q);
  assign taken      = cmd_i.ready && head_valid;

  assign status_o.full      = full;
  assign status_o.empty     = empty;
  assign status_o.skid_held = skid_held_q;
  assign status_o.pending   = pending_q;

  always_comb begin
    result_d = '0;
    result_d[OUT_BITS-1:0] = {cmd_i.push, cnt_q, empty, full, head_valid, head_word};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) result_q <= result_d;
  end
  assign result_o = result_q;

  // storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && cmd_i.push) mem[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && cmd_i.rd) mem_ret_q <= mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      pending_q   <= 1'b0;
      skid_word_q <= '0;
      skid_held_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (cmd_i.flush) begin
        rd_ptr_q    <= wr_ptr_q;
        cnt_q       <= '0;
        pending_q   <= 1'b0;
        skid_word_q <= '0;
        skid_held_q <= 1'b0;
      end else begin
        if (cmd_i.push && !taken)      cnt_q <= cnt_q + cnt_t'(1);
        else if (!cmd_i.push && taken) cnt_q <= cnt_q - cnt_t'(1);
        // returned word not passed straight through parks in the skid
        if (pending_q && !(cmd_i.ready && !skid_held_q)) begin
          skid_held_q <= 1'b1;
          skid_word_q <= mem_ret_q;
        end else if (cmd_i.ready && skid_held_q) begin
          skid_held_q <= 1'b0;
        end
        pending_q <= cmd_i.rd;
        if (cmd_i.push) wr_ptr_q <= wr_ptr_q + addr_t'(1);
        if (cmd_i.rd)   rd_ptr_q <= rd_ptr_q + addr_t'(1);
      end
    end
  end

  a_rd_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && cmd_i.rd |-> !empty)
    else $error("read ahead from empty FIFO");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && cmd_i.push |-> !full && !cmd_i.flush)
    else $error("push while full or flushing");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && cmd_i.flush |=> !skid_held_q && !pending_q && empty && cnt_q == '0)
    else $error("flush left words behind");

  a_read_refills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step && cmd_i.rd |=> pending_q)
    else $error("read ahead lost its return");

endmodule

// ----- hdl/prefetch_fifo_with_skid_buffer.sv -----
// Top level of the prefetch FIFO with skid buffer: stream ports, controller and datapath.
// Depends on pfsb_pkg, pfsb_ctrl and pfsb_datapath.
//
// Every input beat is one clock tick of a FIFO of 1024 x 16 storage holding
// at most 1023 words, read through a registered port; each beat yields exactly
// one result beat describing the FIFO as it stood before that tick, then the
// tick takes effect. One beat is taken per clock cycle unless the output stalls:
// the result register is loaded on the accepting edge and s_axis_tready stays
// high while that register is empty or being drained, so the rate is set by the
// single result register and, on a stalled output, by how soon the consumer
// takes it. No reset sweep: memory entries are only ever read after being written.
module prefetch_fifo_with_skid_buffer import pfsb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input beat
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] write_request, [16:1] write_word, [17] consumer_ready, [18] flush
  input  logic [IN_W-1:0]  s_axis_tdata,
  // result beat
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [15:0] head_word, [16] head_valid, [17] is_full, [18] is_empty,
  // [29:19] occupancy, [30] write_accepted
  output logic [OUT_W-1:0] m_axis_tdata
);

  pfsb_cmd_t    cmd;
  pfsb_status_t status;

  // field unpacking
  logic  wreq, consumer_ready, flush;
  data_t wdata;

  assign wreq           = s_axis_tdata[0];
  assign wdata          = s_axis_tdata[DATA_WIDTH:1];
  assign consumer_ready = s_axis_tdata[DATA_WIDTH+1];
  assign flush          = s_axis_tdata[DATA_WIDTH+2];

  // handshake and per-tick decisions
  pfsb_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .wreq_i           (wreq),
    .consumer_ready_i (consumer_ready),
    .flush_i          (flush),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .status_i         (status),
    .cmd_o            (cmd)
  );

  // pointers, memory, skid and result register
  pfsb_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .wdata_i  (wdata),
    .status_o (status),
    .result_o (m_axis_tdata)
  );

endmodule
